// ===== sv/usb_ep0_control_transfer_top_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef USB_EP0_CONTROL_TRANSFER_TOP_MACROS_SVH
`define USB_EP0_CONTROL_TRANSFER_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define UEP0CT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define UEP0CT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/uep0ct_pkg.sv =====
// types and constants of the endpoint-zero control transfer sequencer
// no dependencies
package uep0ct_pkg;

	// event codes
	localparam logic [2:0] FUNC_SETUP_PKT  = 3'd0;
	localparam logic [2:0] FUNC_SETUP_DONE = 3'd1;
	localparam logic [2:0] FUNC_IN_DONE    = 3'd2;
	localparam logic [2:0] FUNC_OUT_PKT    = 3'd3;
	localparam logic [2:0] FUNC_OUT_DONE   = 3'd4;

	// configuration register addresses
	localparam logic ADDR_MPS = 1'b0;

	localparam logic [6:0] MPS_RESET        = 7'd64;
	localparam logic [6:0] SETUP_PKT_BYTES  = 7'd8;
	localparam logic [7:0] TYPE_DIR_CLEAR   = 8'h7F;

	typedef struct packed {
		logic [2:0]  func;
		logic [6:0]  byte_count;
		logic [31:0] setup_word_low;
		logic [31:0] setup_word_high;
		logic        accept;
		logic        has_status_hook;
		logic [6:0]  source_bytes;
	} ev_item_t;

	typedef struct packed {
		logic        in_arm;
		logic [6:0]  in_size;
		logic        in_stall;
		logic        out_arm;
		logic [6:0]  out_size;
		logic        out_stall;
		logic        status_done;
		logic [7:0]  req_type;
		logic [7:0]  req_code;
		logic [15:0] req_value;
		logic [15:0] req_index;
		logic [15:0] req_length;
	} res_item_t;

endpackage

// ===== sv/uep0ct_seq.sv =====
// transfer state and per-event decision logic
// depends on uep0ct_pkg
module uep0ct_seq import uep0ct_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  ev_item_t   ev,
	input  logic [6:0] mps,
	output res_item_t  res
);

	logic [7:0]  type_q, type_d;
	logic [7:0]  code_q, code_d;
	logic [15:0] value_q, value_d;
	logic [15:0] index_q, index_d;
	logic [15:0] length_q, length_d;
	logic [15:0] left_q, left_d;
	logic        in_status_q, in_status_d;
	logic        out_data_q, out_data_d;
	logic        pend_q, pend_d;

	logic [15:0] left_base, mp16, src16, bc16, n_a, n16, left_sub, left_push;
	logic        push_ok;
	logic [6:0]  out_min;

	// packet sizing
	always_comb begin
		left_base = (ev.func == FUNC_SETUP_DONE) ? length_q : left_q;
		mp16      = {9'd0, mps};
		src16     = {9'd0, ev.source_bytes};
		bc16      = {9'd0, ev.byte_count};
		n_a       = (mp16 < left_base) ? mp16 : left_base;
		n16       = (src16 < n_a) ? src16 : n_a;
		push_ok   = (left_base != 16'd0);
		left_sub  = left_base - n16;
		// short packet ends the data stage
		left_push = (left_sub != 16'd0 && n16 != mp16) ? 16'd0 : left_sub;
		out_min   = n_a[6:0];
	end

	always_comb begin
		type_d      = type_q;
		code_d      = code_q;
		value_d     = value_q;
		index_d     = index_q;
		length_d    = length_q;
		left_d      = left_q;
		in_status_d = in_status_q;
		out_data_d  = out_data_q;
		pend_d      = pend_q;
		res         = '0;
		case (ev.func)
			FUNC_SETUP_PKT: begin
				if (ev.byte_count == SETUP_PKT_BYTES) begin
					type_d   = ev.setup_word_low[7:0];
					code_d   = ev.setup_word_low[15:8];
					value_d  = ev.setup_word_low[31:16];
					index_d  = ev.setup_word_high[15:0];
					length_d = ev.setup_word_high[31:16];
				end
			end
			FUNC_SETUP_DONE: begin
				left_d      = left_base;
				in_status_d = 1'b0;
				out_data_d  = 1'b0;
				pend_d      = 1'b0;
				if (!push_ok) begin
					type_d = type_q & TYPE_DIR_CLEAR;
					if (ev.accept) begin
						in_status_d = 1'b1;
						pend_d      = ev.has_status_hook;
						res.in_arm  = 1'b1;
					end else begin
						res.in_stall = 1'b1;
					end
				end else if (type_q[7]) begin
					if (ev.accept) begin
						pend_d      = ev.has_status_hook;
						res.in_arm  = 1'b1;
						res.in_size = n16[6:0];
						left_d      = left_push;
						res.out_arm = 1'b1;
					end else begin
						res.in_stall  = 1'b1;
						res.out_stall = 1'b1;
					end
				end else begin
					if (ev.accept) begin
						pend_d       = ev.has_status_hook;
						out_data_d   = 1'b1;
						res.out_arm  = 1'b1;
						res.out_size = out_min;
					end else begin
						res.in_stall  = 1'b1;
						res.out_stall = 1'b1;
					end
				end
			end
			FUNC_IN_DONE: begin
				if (in_status_q) begin
					if (pend_q) begin
						res.status_done = 1'b1;
						pend_d          = 1'b0;
						in_status_d     = 1'b0;
					end
				end else if (push_ok) begin
					res.in_arm  = 1'b1;
					res.in_size = n16[6:0];
					left_d      = left_push;
				end
			end
			FUNC_OUT_PKT: begin
				left_d = (bc16 >= left_q) ? 16'd0 : left_q - bc16;
			end
			FUNC_OUT_DONE: begin
				if (out_data_q) begin
					if (left_q == 16'd0) begin
						if (ev.accept) begin
							in_status_d = 1'b1;
							res.in_arm  = 1'b1;
						end else begin
							res.in_stall = 1'b1;
						end
					end else begin
						res.out_arm  = 1'b1;
						res.out_size = out_min;
					end
				end else if (pend_q) begin
					res.status_done = 1'b1;
					pend_d          = 1'b0;
				end
			end
			default: begin
			end
		endcase
		res.req_type   = type_d;
		res.req_code   = code_d;
		res.req_value  = value_d;
		res.req_index  = index_d;
		res.req_length = length_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_q      <= '0;
			code_q      <= '0;
			value_q     <= '0;
			index_q     <= '0;
			length_q    <= '0;
			left_q      <= '0;
			in_status_q <= 1'b0;
			out_data_q  <= 1'b0;
			pend_q      <= 1'b0;
		end else if (adv) begin
			type_q      <= type_d;
			code_q      <= code_d;
			value_q     <= value_d;
			index_q     <= index_d;
			length_q    <= length_d;
			left_q      <= left_d;
			in_status_q <= in_status_d;
			out_data_q  <= out_data_d;
			pend_q      <= pend_d;
		end
	end

endmodule

// ===== sv/usb_ep0_control_transfer_top.sv =====
// top level of the endpoint-zero control transfer sequencer
// depends on uep0ct_pkg and uep0ct_seq
// a request taken is held in the input register, then its result is registered in the result register
// throughput: one request per cycle unless a finished result is stalled, set by the single state update in uep0ct_seq
// reset: arst_n clears the setup fields, byte count, stage and pending flags and
// both valid bits; the packet size limit returns to 64
module usb_ep0_control_transfer_top import uep0ct_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// event channel
	input  logic        ev_valid,
	output logic        ev_stall,
	input  ev_item_t    ev,
	// result channel
	output logic        res_valid,
	input  logic        res_stall,
	output res_item_t   res,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// input register
	ev_item_t   ev_s1;
	logic       ev_vld_s1;
	// result register
	res_item_t  res_s2;
	logic       res_vld_s2;
	// configuration
	logic [6:0] mps_q;

	res_item_t  res_next;
	logic       adv;

	// the held request moves on unless a finished result is still stuck
	assign adv      = ev_vld_s1 && !(res_vld_s2 && res_stall);
	// input slot is free when empty or emptying this cycle
	assign ev_stall = ev_vld_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_vld_s1 <= 1'b0;
		end else if (!ev_stall) begin
			ev_vld_s1 <= ev_valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (!ev_stall && ev_valid) begin
			ev_s1 <= ev;
		end
	end

	// decision logic and transfer state
	uep0ct_seq seq_i (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.ev     (ev_s1),
		.mps    (mps_q),
		.res    (res_next)
	);

	// result register holds while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_s2 <= 1'b0;
		end else if (adv) begin
			res_vld_s2 <= 1'b1;
		end else if (!res_stall) begin
			res_vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_next;
		end
	end

	assign res_valid = res_vld_s2;
	assign res       = res_s2;

	// register file: packet size limit only, no wait states
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mps_q <= MPS_RESET;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_MPS) begin
			mps_q <= pwdata[6:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_MPS) begin
			prdata = {25'd0, mps_q};
		end
	end

endmodule

// ===== sv/uep0ct_chk.sv =====
// port-level checker for the endpoint-zero sequencer, bound to the top level
// depends on uep0ct_pkg and the assertion macro header
`include "usb_ep0_control_transfer_top_macros.svh"

module uep0ct_chk import uep0ct_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        ev_stall,
	input logic        res_valid,
	input logic        res_stall,
	input res_item_t   res
);

	logic res_wait;
	logic size_ok;
	logic armed;
	logic ep_action;

	assign res_wait  = res_valid && res_stall;
	assign size_ok   = (res.in_size == 7'd0 || res.in_arm) && (res.out_size == 7'd0 || res.out_arm);
	assign armed     = res.in_arm || res.out_arm;
	assign ep_action = armed || res.in_stall || res.out_stall;

	`UEP0CT_ASSERT_NEXT(a_res_hold, clk, arst_n, res_wait, res_valid && $stable(res), "result changed")
	`UEP0CT_ASSERT_IMPLY(a_stall_cause, clk, arst_n, ev_stall, res_wait, "event stalled, result free")
	`UEP0CT_ASSERT_IMPLY(a_size_armed, clk, arst_n, res_valid, size_ok, "size without arm")
	`UEP0CT_ASSERT_IMPLY(a_arm_stall, clk, arst_n, res_valid && res.in_stall, !armed, "armed and stalled")
	`UEP0CT_ASSERT_IMPLY(a_done_alone, clk, arst_n, res_valid && res.status_done, !ep_action, "done with action")

endmodule

bind usb_ep0_control_transfer_top uep0ct_chk chk_i (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// self-checking bench for usb_ep0_control_transfer_top: directed and random control
// transfers are checked against an in-bench model of the endpoint-zero sequencer
// depends on uep0ct_pkg and the sequencer rtl
module tb_top;
	import uep0ct_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        ev_valid = 1'b0;
	logic        ev_stall;
	ev_item_t    ev = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	res_item_t   res;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic        paddr = ADDR_MPS;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	usb_ep0_control_transfer_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.ev_valid (ev_valid),
		.ev_stall (ev_stall),
		.ev       (ev),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// requests waiting to be driven, and results owed by the block in order
	ev_item_t  ep0_events[$];
	res_item_t ep0_due[$];

	int mismatches = 0;
	int ev_gap = 0;
	int stall_left = 0;
	// set for the last phase: no gaps and no stalls
	bit calm = 1'b0;

	// shadow of the sequencer: stored setup fields, byte count and stage flags
	logic [6:0]  max_pkt = MPS_RESET;
	logic [7:0]  req_type_q = '0;
	logic [7:0]  req_code_q = '0;
	logic [15:0] req_value_q = '0;
	logic [15:0] req_index_q = '0;
	logic [15:0] req_length_q = '0;
	logic [15:0] remaining = '0;
	logic        in_status = 1'b0;
	logic        out_data = 1'b0;
	logic        notify_pending = 1'b0;

	// in packet size: min of max packet, bytes left and source bytes;
	// a short packet (not max packet, bytes still left) ends the data stage
	function automatic logic load_in_packet(input logic [6:0] avail, output logic [6:0] size);
		logic [15:0] n;
		size = '0;
		if (remaining == '0)
			return 1'b0;
		n = (16'(max_pkt) < remaining) ? 16'(max_pkt) : remaining;
		if (16'(avail) < n)
			n = 16'(avail);
		remaining = remaining - n;
		if (remaining != '0 && n != 16'(max_pkt))
			remaining = '0;
		size = n[6:0];
		return 1'b1;
	endfunction

	function automatic logic [6:0] out_chunk();
		return (16'(max_pkt) < remaining) ? max_pkt : remaining[6:0];
	endfunction

	// expected result of one request; advances the shadow state
	function automatic res_item_t ep0_outcome(input ev_item_t e);
		res_item_t r;
		logic [6:0] sz;
		r = '0;
		case (e.func)
			FUNC_SETUP_PKT: begin
				// anything but an 8-byte setup packet is dropped
				if (e.byte_count == SETUP_PKT_BYTES) begin
					req_type_q = e.setup_word_low[7:0];
					req_code_q = e.setup_word_low[15:8];
					req_value_q = e.setup_word_low[31:16];
					req_index_q = e.setup_word_high[15:0];
					req_length_q = e.setup_word_high[31:16];
				end
			end
			FUNC_SETUP_DONE: begin
				remaining = req_length_q;
				in_status = 1'b0;
				out_data = 1'b0;
				notify_pending = 1'b0;
				if (remaining == '0) begin
					// no data stage: direction bit dropped, status goes in
					req_type_q = req_type_q & TYPE_DIR_CLEAR;
					if (e.accept) begin
						in_status = 1'b1;
						notify_pending = e.has_status_hook;
						r.in_arm = 1'b1;
					end else begin
						r.in_stall = 1'b1;
					end
				end else if (!e.accept) begin
					r.in_stall = 1'b1;
					r.out_stall = 1'b1;
				end else if (req_type_q[7]) begin
					notify_pending = e.has_status_hook;
					r.in_arm = load_in_packet(e.source_bytes, sz);
					r.in_size = sz;
					r.out_arm = 1'b1;
				end else begin
					notify_pending = e.has_status_hook;
					out_data = 1'b1;
					r.out_arm = 1'b1;
					r.out_size = out_chunk();
				end
			end
			FUNC_IN_DONE: begin
				if (in_status) begin
					// status stage stays open when nothing is pending
					if (notify_pending) begin
						r.status_done = 1'b1;
						notify_pending = 1'b0;
						in_status = 1'b0;
					end
				end else begin
					r.in_arm = load_in_packet(e.source_bytes, sz);
					r.in_size = sz;
				end
			end
			FUNC_OUT_PKT: begin
				// saturating at zero
				remaining = (16'(e.byte_count) >= remaining) ? '0 : remaining - 16'(e.byte_count);
			end
			FUNC_OUT_DONE: begin
				if (out_data) begin
					if (remaining == '0) begin
						if (e.accept) begin
							in_status = 1'b1;
							r.in_arm = 1'b1;
						end else begin
							r.in_stall = 1'b1;
						end
					end else begin
						r.out_arm = 1'b1;
						r.out_size = out_chunk();
					end
				end else if (notify_pending) begin
					// out status of an in transfer
					r.status_done = 1'b1;
					notify_pending = 1'b0;
				end
			end
			default: begin
			end
		endcase
		r.req_type = req_type_q;
		r.req_code = req_code_q;
		r.req_value = req_value_q;
		r.req_index = req_index_q;
		r.req_length = req_length_q;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t mismatch on %s: expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	// driver: holds a stalled request, otherwise takes the next one or idles
	always @(posedge clk) begin
		if (!arst_n) begin
			ev_valid <= 1'b0;
		end else begin
			if (ev_valid && !ev_stall)
				ep0_due.push_back(ep0_outcome(ev));
			if (!(ev_valid && ev_stall)) begin
				if (ev_gap > 0) begin
					ev_gap--;
					ev_valid <= 1'b0;
				end else if (ep0_events.size() > 0) begin
					ev <= ep0_events.pop_front();
					ev_valid <= 1'b1;
					// a burst of idle cycles after this request now and then
					if (!calm && $urandom_range(0, 7) == 0)
						ev_gap = $urandom_range(1, 10);
				end else begin
					ev_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks every taken result against the oldest one owed,
	// and stalls the result channel in random bursts
	res_item_t want;
	always @(posedge clk) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (ep0_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t result with nothing expected: %h", $time, res);
				end else begin
					want = ep0_due.pop_front();
					check_field("in_arm", 16'(want.in_arm), 16'(res.in_arm));
					check_field("in_size", 16'(want.in_size), 16'(res.in_size));
					check_field("in_stall", 16'(want.in_stall), 16'(res.in_stall));
					check_field("out_arm", 16'(want.out_arm), 16'(res.out_arm));
					check_field("out_size", 16'(want.out_size), 16'(res.out_size));
					check_field("out_stall", 16'(want.out_stall), 16'(res.out_stall));
					check_field("status_done", 16'(want.status_done), 16'(res.status_done));
					check_field("req_type", 16'(want.req_type), 16'(res.req_type));
					check_field("req_code", 16'(want.req_code), 16'(res.req_code));
					check_field("req_value", want.req_value, res.req_value);
					check_field("req_index", want.req_index, res.req_index);
					check_field("req_length", want.req_length, res.req_length);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				res_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 9);
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	task automatic push_ev(input logic [2:0] f, input logic [6:0] bc, input logic [31:0] lo,
			input logic [31:0] hi, input logic acc, input logic hook, input logic [6:0] src);
		ev_item_t e;
		e.func = f;
		e.byte_count = bc;
		e.setup_word_low = lo;
		e.setup_word_high = hi;
		e.accept = acc;
		e.has_status_hook = hook;
		e.source_bytes = src;
		ep0_events.push_back(e);
	endtask

	function automatic logic [6:0] any_count();
		return 7'($urandom_range(0, 64));
	endfunction

	// the source mostly has a full packet ready
	function automatic logic [6:0] pick_src();
		return ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 64)) : 7'd64;
	endfunction

	function automatic logic any_bit();
		return 1'($urandom_range(0, 1));
	endfunction

	// one control transfer: setup packet, setup done, data stage and status
	task automatic add_transfer();
		int kind;
		int left_g;
		int chunk;
		int n;
		logic [15:0] len;
		logic [31:0] lo;
		logic [6:0] bc;
		logic acc;
		kind = $urandom_range(0, 2);
		if (kind == 0)
			len = '0;
		else if ($urandom_range(0, 15) == 0)
			len = 16'($urandom);
		else
			len = 16'($urandom_range(1, 300));
		lo = $urandom;
		if (kind == 1)
			lo[7] = 1'b1;
		else if (kind == 2)
			lo[7] = 1'b0;
		// a broken setup packet ahead of the real one now and then
		if ($urandom_range(0, 7) == 0) begin
			bc = 7'($urandom_range(0, 63));
			if (bc >= SETUP_PKT_BYTES)
				bc++;
			push_ev(FUNC_SETUP_PKT, bc, $urandom, $urandom, any_bit(), any_bit(), any_count());
		end
		push_ev(FUNC_SETUP_PKT, SETUP_PKT_BYTES, lo, {len, 16'($urandom)}, any_bit(), any_bit(),
			any_count());
		acc = ($urandom_range(0, 7) != 0);
		push_ev(FUNC_SETUP_DONE, any_count(), $urandom, $urandom, acc, any_bit(), pick_src());
		if (!acc)
			return;
		case (kind)
			0: push_ev(FUNC_IN_DONE, any_count(), $urandom, $urandom, any_bit(), any_bit(),
				any_count());
			1: begin
				n = $urandom_range(0, 10);
				repeat (n)
					push_ev(FUNC_IN_DONE, any_count(), $urandom, $urandom, any_bit(), any_bit(),
						pick_src());
				push_ev(FUNC_OUT_DONE, any_count(), $urandom, $urandom, any_bit(), any_bit(),
					any_count());
			end
			default: begin
				left_g = int'(len);
				n = 0;
				while (left_g > 0 && n < 12) begin
					chunk = (int'(max_pkt) < left_g) ? int'(max_pkt) : left_g;
					if (chunk > 64 || $urandom_range(0, 3) == 0)
						chunk = $urandom_range(0, 64);
					push_ev(FUNC_OUT_PKT, 7'(chunk), $urandom, $urandom, any_bit(), any_bit(),
						any_count());
					left_g = (chunk >= left_g) ? 0 : left_g - chunk;
					push_ev(FUNC_OUT_DONE, any_count(), $urandom, $urandom,
						(left_g > 0) ? 1'b1 : ($urandom_range(0, 5) != 0), any_bit(), any_count());
					n++;
				end
				if (left_g == 0)
					push_ev(FUNC_IN_DONE, any_count(), $urandom, $urandom, any_bit(), any_bit(),
						any_count());
			end
		endcase
	endtask

	// mostly whole transfers, one in ten a lone request of any code
	task automatic fill_random(input int count);
		int start;
		start = ep0_events.size();
		while (ep0_events.size() - start < count) begin
			if ($urandom_range(0, 9) == 0)
				push_ev(3'($urandom_range(0, 7)), any_count(), $urandom, $urandom, any_bit(),
					any_bit(), any_count());
			else
				add_transfer();
		end
	endtask

	// hand-picked corner cases at the reset packet size of 64
	task automatic add_directed();
		// short setup packet dropped
		push_ev(FUNC_SETUP_PKT, 7'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 7'd64);
		// no-data request with direction bit set, notification wanted
		push_ev(FUNC_SETUP_PKT, SETUP_PKT_BYTES, 32'hFFFF_FFFF, 32'h0000_FFFF, 1'b0, 1'b0, 7'd0);
		push_ev(FUNC_SETUP_DONE, 7'd0, 32'h0, 32'h0, 1'b1, 1'b1, 7'd0);
		push_ev(FUNC_IN_DONE, 7'd0, 32'h0, 32'h0, 1'b0, 1'b0, 7'd0);
		// accepted without hook: status stage stays open
		push_ev(FUNC_SETUP_DONE, 7'd64, 32'h0, 32'h0, 1'b1, 1'b0, 7'd64);
		push_ev(FUNC_IN_DONE, 7'd0, 32'h0, 32'h0, 1'b1, 1'b1, 7'd64);
		push_ev(FUNC_OUT_DONE, 7'd0, 32'h0, 32'h0, 1'b1, 1'b1, 7'd64);
		// rejected no-data request
		push_ev(FUNC_SETUP_DONE, 7'd0, 32'h0, 32'h0, 1'b0, 1'b1, 7'd64);
		// in transfer of 150 bytes: rejected, then sent as 64, 64, 22
		push_ev(FUNC_SETUP_PKT, SETUP_PKT_BYTES, 32'hA55A_0680, {16'd150, 16'h0000}, 1'b0, 1'b0,
			7'd0);
		push_ev(FUNC_SETUP_DONE, 7'd0, 32'h0, 32'h0, 1'b0, 1'b1, 7'd64);
		push_ev(FUNC_SETUP_DONE, 7'd0, 32'h0, 32'h0, 1'b1, 1'b1, 7'd64);
		push_ev(FUNC_IN_DONE, 7'd0, 32'h0, 32'h0, 1'b0, 1'b0, 7'd64);
		push_ev(FUNC_IN_DONE, 7'd0, 32'h0, 32'h0, 1'b0, 1'b0, 7'd64);
		push_ev(FUNC_IN_DONE, 7'd0, 32'h0, 32'h0, 1'b0, 1'b0, 7'd64);
		// status out completes the pending notification
		push_ev(FUNC_OUT_DONE, 7'd0, 32'h0, 32'h0, 1'b0, 1'b0, 7'd0);
		// out transfer of 100 bytes, second packet overruns and saturates
		push_ev(FUNC_SETUP_PKT, SETUP_PKT_BYTES, 32'h1234_5600, {16'd100, 16'hABCD}, 1'b1, 1'b1,
			7'd63);
		push_ev(FUNC_SETUP_DONE, 7'd0, 32'h0, 32'h0, 1'b1, 1'b1, 7'd0);
		push_ev(FUNC_OUT_PKT, 7'd64, 32'h0, 32'h0, 1'b0, 1'b0, 7'd0);
		push_ev(FUNC_OUT_DONE, 7'd0, 32'h0, 32'h0, 1'b1, 1'b0, 7'd0);
		push_ev(FUNC_OUT_PKT, 7'd63, 32'h0, 32'h0, 1'b0, 1'b0, 7'd0);
		push_ev(FUNC_OUT_DONE, 7'd0, 32'h0, 32'h0, 1'b0, 1'b0, 7'd0);
		push_ev(FUNC_OUT_DONE, 7'd0, 32'h0, 32'h0, 1'b1, 1'b0, 7'd0);
		push_ev(FUNC_IN_DONE, 7'd0, 32'h0, 32'h0, 1'b0, 1'b0, 7'd0);
		// codes past the last event are ignored
		push_ev(3'd5, 7'd64, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 7'd64);
		push_ev(3'd7, 7'd8, 32'h0, 32'h0, 1'b1, 1'b1, 7'd64);
	endtask

	// wait until no request is queued or in flight and no result is owed
	task automatic drain();
		while (ep0_events.size() != 0 || ev_valid || ep0_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// apb write then read back of the packet size limit, only while the block is idle
	task automatic write_mps(input logic [6:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_MPS;
		pwdata <= 32'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// write taken here; read setup follows at once
		max_pkt = val;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[6:0] !== val) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t packet size read back: expected %0h, got %0h", $time, val,
					prdata[6:0]);
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// packet sizes per phase: the legal extremes, an odd size and zero;
	// the first phase runs at the reset value
	logic [6:0] pkt_sizes[6] = '{7'd8, 7'd32, 7'd13, 7'd0, 7'd16, 7'd64};

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		add_directed();
		fill_random(250);
		drain();
		foreach (pkt_sizes[i]) begin
			// last phase runs flat out
			if (i == 5)
				calm = 1'b1;
			write_mps(pkt_sizes[i]);
			fill_random(290);
			drain();
		end
		repeat (8) @(posedge clk);
		if (mismatches == 0 && ep0_due.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#1_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
